// ===== rtl/dgd_pkg.sv =====
`default_nettype none

package dgd_pkg;

  // Field widths of one date.
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;

  // Day of year (up to 366), leap years below a year (up to 3973 for the
  // largest 14-bit year), quotient of a year by 100 (up to 163).
  localparam int DOY_W   = 9;
  localparam int LEAPS_W = 12;
  localparam int Q100_W  = 8;

  // Signed day count and the packed stream words.
  localparam int CNT_W      = 24;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // Year limits of a valid date: strictly above the lower bound, at most the upper.
  localparam int unsigned YEAR_FLOOR = 1950;
  localparam int unsigned MAX_YEAR   = 16383;

  // floor(y / 100) == (y * 5243) >> 19 for every y below 2**15.
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_MUL_W = 13;
  localparam int DIV100_SHIFT = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUR_DAY   = 2'd0,
    CFG_CUR_MONTH = 2'd1,
    CFG_CUR_YEAR  = 2'd2
  } dgd_cfg_idx_e;

  // Calendar facts of one date, passed from the calendar unit to the pipeline.
  typedef struct packed {
    logic [DOY_W-1:0]   doy;
    logic [LEAPS_W-1:0] leaps;
    logic [DAY_W-1:0]   mlen;
  } dgd_cal_t;

endpackage

`default_nettype wire

// ===== rtl/dgd_div100.sv =====
`default_nettype none

module dgd_div100 (
  input  wire logic [dgd_pkg::YEAR_W-1:0] year_i,
  output logic      [dgd_pkg::Q100_W-1:0] quot_o
);
  import dgd_pkg::*;

  localparam int ProdW = YEAR_W + DIV100_MUL_W;

  logic [ProdW-1:0] prod;

  // Reciprocal multiply; exact for all 14-bit years.
  assign prod   = {{DIV100_MUL_W{1'b0}}, year_i} * ProdW'(DIV100_MUL);
  assign quot_o = prod[DIV100_SHIFT +: Q100_W];

endmodule

`default_nettype wire

// ===== rtl/dgd_calendar.sv =====
`default_nettype none

module dgd_calendar (
  input  wire logic [dgd_pkg::DAY_W-1:0]  day_i,
  input  wire logic [dgd_pkg::MON_W-1:0]  month_i,
  input  wire logic [dgd_pkg::YEAR_W-1:0] year_i,
  input  wire logic [dgd_pkg::Q100_W-1:0] quot_i,
  output dgd_pkg::dgd_cal_t               cal_o
);
  import dgd_pkg::*;

  // Days in all months below the given one; months past December stop at
  // the sum of January to November.
  function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      default:    r = 9'd334;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  logic [YEAR_W:0]    hund;
  logic               rem_zero;
  logic               leap;
  logic [Q100_W:0]    c100;
  logic [Q100_W:0]    c100_p3;
  logic [YEAR_W:0]    year_p3;
  logic [YEAR_W-2:0]  c4;
  logic [YEAR_W-2:0]  leaps_full;
  logic               feb_passed;

  assign hund     = {{(YEAR_W+1-Q100_W){1'b0}}, quot_i} * (YEAR_W+1)'(100);
  assign rem_zero = (hund == {1'b0, year_i});
  // Divisible by 400 means divisible by 100 with a quotient divisible by 4.
  assign leap     = (year_i[1:0] == 2'b00) && (!rem_zero || (quot_i[1:0] == 2'b00));

  // Leap years in [0, y): ceil(y/4) - ceil(y/100) + ceil(y/400), where
  // ceil(y/400) is ceil(ceil(y/100)/4).
  assign c100       = {1'b0, quot_i} + {{Q100_W{1'b0}}, ~rem_zero};
  assign c100_p3    = c100 + (Q100_W+1)'(3);
  assign year_p3    = {1'b0, year_i} + (YEAR_W+1)'(3);
  assign c4         = year_p3[YEAR_W:2];
  assign leaps_full = c4 - {{(YEAR_W-2-Q100_W){1'b0}}, c100}
                    + {{(YEAR_W-Q100_W){1'b0}}, c100_p3[Q100_W:2]};

  assign feb_passed = (month_i >= 4'd3);

  assign cal_o.leaps = leaps_full[LEAPS_W-1:0];
  assign cal_o.mlen  = month_len(month_i, leap);
  assign cal_o.doy   = {{(DOY_W-DAY_W){1'b0}}, day_i} + days_before(month_i)
                     + {{(DOY_W-1){1'b0}}, leap && feb_passed};

endmodule

`default_nettype wire

// ===== rtl/gregorian_date_check_and_difference.sv =====
`default_nettype none

// Channel   | Dir | Beat fields, lowest bit first
// ----------+-----+---------------------------------------------------------------
// s_axis    | in  | day_a[4:0] month_a[8:5] year_a[22:9] day_b[27:23]
//           |     |   month_b[31:28] year_b[45:32], bits 47:46 zero
// m_axis    | out | a_valid[0] a_not_before_current[1] a_not_before_b[2]
//           |     |   days_between[26:3] (signed), bits 31:27 zero
// cfg       | in  | index 0 current day, 1 current month, 2 current year
//
// Each input beat yields one output beat; unless full and stalled, the pipeline
// takes one beat per cycle. The five register stages are: compare and order the
// two dates, divide both years by 100 (two reciprocal multipliers), calendar
// facts (leap year, day of year, leap years below), year span, and the output
// register. Reset empties the pipeline and sets the current date to 1/1/1951.
// Every stage holds its beat while the stage after it is full and stalled, so a
// stall at m_axis only backs up as far as the pipeline is occupied.

module gregorian_date_check_and_difference (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // day_a, month_a, year_a, day_b, month_b, year_b from bit 0 up
  input  wire logic [dgd_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // a_valid, a_not_before_current, a_not_before_b, days_between from bit 0 up
  output logic      [dgd_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [dgd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [dgd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import dgd_pkg::*;

  localparam int NStages = 5;
  localparam int DateW   = DAY_W + MON_W + YEAR_W;

  // ---------------------------------------------------------------------------
  // Current date registers
  // ---------------------------------------------------------------------------
  logic [DAY_W-1:0]  cur_day_q;
  logic [MON_W-1:0]  cur_month_q;
  logic [YEAR_W-1:0] cur_year_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_day_q   <= DAY_W'(1);
      cur_month_q <= MON_W'(1);
      cur_year_q  <= YEAR_W'(1951);
    end else if (cfg_we_i) begin
      case (dgd_cfg_idx_e'(cfg_idx_i))
        CFG_CUR_DAY:   cur_day_q   <= cfg_wdata_i[DAY_W-1:0];
        CFG_CUR_MONTH: cur_month_q <= cfg_wdata_i[MON_W-1:0];
        CFG_CUR_YEAR:  cur_year_q  <= cfg_wdata_i[YEAR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its beat moves on.
  // ---------------------------------------------------------------------------
  logic [NStages-1:0] v_q;
  logic [NStages-1:0] en;

  always_comb begin
    en[NStages-1] = !v_q[NStages-1] || m_axis_tready_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = v_q[NStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: unpack, compare, and put the later date first.
  // ---------------------------------------------------------------------------
  logic [DAY_W-1:0]  in_day_a, in_day_b;
  logic [MON_W-1:0]  in_mon_a, in_mon_b;
  logic [YEAR_W-1:0] in_year_a, in_year_b;
  logic [DateW-1:0]  key_a, key_b, key_cur;
  logic              ge_b, ge_cur, yr_ok;

  assign in_day_a  = s_axis_tdata_i[4:0];
  assign in_mon_a  = s_axis_tdata_i[8:5];
  assign in_year_a = s_axis_tdata_i[22:9];
  assign in_day_b  = s_axis_tdata_i[27:23];
  assign in_mon_b  = s_axis_tdata_i[31:28];
  assign in_year_b = s_axis_tdata_i[45:32];

  // Year, then month, then day: one compare on the concatenated key.
  assign key_a   = {in_year_a, in_mon_a, in_day_a};
  assign key_b   = {in_year_b, in_mon_b, in_day_b};
  assign key_cur = {cur_year_q, cur_month_q, cur_day_q};
  assign ge_b    = (key_a >= key_b);
  assign ge_cur  = (key_a >= key_cur);
  assign yr_ok   = (32'(in_year_a) > YEAR_FLOOR) && (32'(in_year_a) <= MAX_YEAR);

  logic              s0_ge_b_q, s0_ge_cur_q, s0_yr_ok_q;
  logic [DAY_W-1:0]  s0_dl_q, s0_de_q;
  logic [MON_W-1:0]  s0_ml_q, s0_me_q;
  logic [YEAR_W-1:0] s0_yl_q, s0_ye_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_ge_b_q   <= ge_b;
      s0_ge_cur_q <= ge_cur;
      s0_yr_ok_q  <= yr_ok;
      s0_dl_q     <= ge_b ? in_day_a  : in_day_b;
      s0_ml_q     <= ge_b ? in_mon_a  : in_mon_b;
      s0_yl_q     <= ge_b ? in_year_a : in_year_b;
      s0_de_q     <= ge_b ? in_day_b  : in_day_a;
      s0_me_q     <= ge_b ? in_mon_b  : in_mon_a;
      s0_ye_q     <= ge_b ? in_year_b : in_year_a;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: both years divided by 100.
  // ---------------------------------------------------------------------------
  logic [Q100_W-1:0] ql, qe;

  dgd_div100 u_div_late (
    .year_i (s0_yl_q),
    .quot_o (ql)
  );

  dgd_div100 u_div_early (
    .year_i (s0_ye_q),
    .quot_o (qe)
  );

  logic              s1_ge_b_q, s1_ge_cur_q, s1_yr_ok_q;
  logic [DAY_W-1:0]  s1_dl_q, s1_de_q;
  logic [MON_W-1:0]  s1_ml_q, s1_me_q;
  logic [YEAR_W-1:0] s1_yl_q, s1_ye_q;
  logic [Q100_W-1:0] s1_ql_q, s1_qe_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_ge_b_q   <= s0_ge_b_q;
      s1_ge_cur_q <= s0_ge_cur_q;
      s1_yr_ok_q  <= s0_yr_ok_q;
      s1_dl_q     <= s0_dl_q;
      s1_ml_q     <= s0_ml_q;
      s1_yl_q     <= s0_yl_q;
      s1_de_q     <= s0_de_q;
      s1_me_q     <= s0_me_q;
      s1_ye_q     <= s0_ye_q;
      s1_ql_q     <= ql;
      s1_qe_q     <= qe;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: calendar facts of both dates and the validity of date A.
  // ---------------------------------------------------------------------------
  dgd_cal_t          cal_l, cal_e;
  logic [DAY_W-1:0]  day_a2, mlen_a2;
  logic              valid2;

  dgd_calendar u_cal_late (
    .day_i   (s1_dl_q),
    .month_i (s1_ml_q),
    .year_i  (s1_yl_q),
    .quot_i  (s1_ql_q),
    .cal_o   (cal_l)
  );

  dgd_calendar u_cal_early (
    .day_i   (s1_de_q),
    .month_i (s1_me_q),
    .year_i  (s1_ye_q),
    .quot_i  (s1_qe_q),
    .cal_o   (cal_e)
  );

  // Date A sits on the late side exactly when it is not before B. A month
  // outside 1 to 12 has length zero, so no day fits it.
  assign day_a2  = s1_ge_b_q ? s1_dl_q    : s1_de_q;
  assign mlen_a2 = s1_ge_b_q ? cal_l.mlen : cal_e.mlen;
  assign valid2  = s1_yr_ok_q && (day_a2 != '0) && (day_a2 <= mlen_a2);

  logic               s2_ge_b_q, s2_ge_cur_q, s2_valid_q;
  logic [DOY_W-1:0]   s2_doyl_q, s2_doye_q;
  logic [LEAPS_W-1:0] s2_lbl_q, s2_lbe_q;
  logic [YEAR_W-1:0]  s2_dy_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_ge_b_q   <= s1_ge_b_q;
      s2_ge_cur_q <= valid2 && s1_ge_cur_q;
      s2_valid_q  <= valid2;
      s2_doyl_q   <= cal_l.doy;
      s2_doye_q   <= cal_e.doy;
      s2_lbl_q    <= cal_l.leaps;
      s2_lbe_q    <= cal_e.leaps;
      s2_dy_q     <= s1_yl_q - s1_ye_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: days of the whole years between, and the day-of-year difference.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] span3, ddoy3;

  assign span3 = {{(CNT_W-YEAR_W){1'b0}}, s2_dy_q} * CNT_W'(365)
               + {{(CNT_W-LEAPS_W){1'b0}}, s2_lbl_q}
               - {{(CNT_W-LEAPS_W){1'b0}}, s2_lbe_q};
  assign ddoy3 = {{(CNT_W-DOY_W){1'b0}}, s2_doyl_q}
               - {{(CNT_W-DOY_W){1'b0}}, s2_doye_q};

  logic             s3_ge_b_q, s3_ge_cur_q, s3_valid_q;
  logic [CNT_W-1:0] s3_span_q, s3_ddoy_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_ge_b_q   <= s2_ge_b_q;
      s3_ge_cur_q <= s2_ge_cur_q;
      s3_valid_q  <= s2_valid_q;
      s3_span_q   <= span3;
      s3_ddoy_q   <= ddoy3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: output register. The count wraps modulo 2**24, which gives the
  // two's complement value when invalid dates make it negative.
  // ---------------------------------------------------------------------------
  logic [OUT_DATA_W-1:0] out_q;
  logic [CNT_W-1:0]      cnt4;

  assign cnt4 = s3_span_q + s3_ddoy_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      out_q <= {(OUT_DATA_W-CNT_W-3)'(0), cnt4, s3_ge_b_q, s3_ge_cur_q, s3_valid_q};
    end
  end

  assign m_axis_tdata_o = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // With the output register free, every stage can move, so input is taken.
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while the output register is empty");

  // Input back-pressure only when every stage holds a beat.
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&v_q))
    else $error("input blocked with an empty stage in the pipeline");

  // An accepted beat always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v_q[0])
    else $error("accepted beat lost at the first stage");

  // A date not before the current date must first be a valid date.
  a_cur_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[1] && !m_axis_tdata_o[0]))
    else $error("a_not_before_current set for an invalid date");

  // A beat in a stalled stage 3 stays put.
  a_stage3_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && !en[3]) |=> (v_q[3] && $stable(s3_span_q) && $stable(s3_ddoy_q)))
    else $error("stalled beat in stage 3 changed");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dgd_pkg::*;

  // The run is cut off here. The slowest correct run (every beat waiting out the
  // longest sender gap and the longest receiver stall) stays well below it.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Five register stages from input beat to output beat.
  localparam int PIPE_DEPTH = 5;
  // Mismatch lines beyond this count are still counted but no longer printed.
  localparam int MAX_PRINTED = 40;
  localparam int N_SETTINGS = 5;
  localparam int RANDOM_PER_PHASE = 72;

  // Current-date settings after the reset one: the highest and lowest values
  // every register takes, then a few ordinary dates.
  localparam int unsigned SET_DAY[N_SETTINGS]  = '{31, 0, 15, 29, 1};
  localparam int unsigned SET_MON[N_SETTINGS]  = '{15, 0, 6, 2, 12};
  localparam int unsigned SET_YEAR[N_SETTINGS] = '{16383, 0, 2000, 2024, 1999};

  // One calendar date. Laid out so that the packed value orders dates by year,
  // then month, then day, which is exactly the ordering the block uses.
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } date_t;

  // One input beat: date A in the low bits, date B above it.
  typedef struct packed {
    date_t b;
    date_t a;
  } date_pair_t;

  // What the block is expected to say about one date pair.
  typedef struct {
    logic                    a_valid;
    logic                    a_not_before_cur;
    logic                    a_not_before_b;
    logic signed [CNT_W-1:0] days;
  } date_verdict_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // The testbench's own copy of the current-date registers, at their reset values.
  date_t cur_date = '{year: 14'd1951, month: 4'd1, day: 5'd1};

  date_pair_t    pending_pairs[$];
  date_verdict_t expected_verdicts[$];

  int unsigned mismatches   = 0;
  int unsigned pairs_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  bit          in_taken     = 1'b0;
  // While set, neither side inserts idle cycles.
  bit          steady       = 1'b0;

  always #5 clk_i = ~clk_i;

  gregorian_date_check_and_difference dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Calendar arithmetic used for the prediction.
  // ---------------------------------------------------------------------------

  // Gregorian rule: every fourth year, except centuries not divisible by 400.
  // Year 0 follows the same rule and so counts as a leap year.
  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Month numbers outside 1..12 have no length at all.
  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit is_real_date(date_t t);
    if (t.year <= YEAR_FLOOR || t.year > MAX_YEAR || t.day == 0) return 1'b0;
    return t.day <= days_in_month(t.month, t.year);
  endfunction

  // Leap years in [0, y).
  function automatic int unsigned leaps_before(int unsigned y);
    return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  // The day plus the lengths of the months below it. Month 0 adds nothing, and
  // months 13 to 15 stop after November, just as month 12 does.
  function automatic int unsigned day_of_year(date_t t);
    int unsigned sum;
    sum = t.day;
    for (int unsigned i = 1; i < t.month && i < 12; i++)
      sum += days_in_month(i, t.year);
    return sum;
  endfunction

  // Full prediction for one pair. The count is worked out from the raw fields
  // even when a date is invalid; with odd months it can come out negative, and
  // the modulo arithmetic below yields the same 24-bit two's complement value.
  function automatic date_verdict_t judge_dates(date_pair_t p);
    date_verdict_t v;
    date_t         later;
    date_t         earlier;
    int unsigned   total;
    v.a_valid          = is_real_date(p.a);
    v.a_not_before_b   = (p.a >= p.b);
    v.a_not_before_cur = v.a_valid && (p.a >= cur_date);
    later   = v.a_not_before_b ? p.a : p.b;
    earlier = v.a_not_before_b ? p.b : p.a;
    total = 365 * (later.year - earlier.year) + leaps_before(later.year)
            - leaps_before(earlier.year) + day_of_year(later) - day_of_year(earlier);
    v.days = total[CNT_W-1:0];
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic date_pair_t make_pair(int unsigned da, int unsigned ma, int unsigned ya,
                                           int unsigned db, int unsigned mb, int unsigned yb);
    date_pair_t p;
    p.a = '{year: ya[YEAR_W-1:0], month: ma[MON_W-1:0], day: da[DAY_W-1:0]};
    p.b = '{year: yb[YEAR_W-1:0], month: mb[MON_W-1:0], day: db[DAY_W-1:0]};
    return p;
  endfunction

  // A date that is usually real: mostly months 1..12 and days that fit the
  // month, with now and then a day or month out of range.
  function automatic date_t plausible_date(int unsigned y_lo, int unsigned y_hi);
    date_t       t;
    int unsigned lim;
    t.year  = YEAR_W'($urandom_range(y_hi, y_lo));
    t.month = MON_W'(($urandom_range(99) < 88) ? $urandom_range(12, 1)
                                                : $urandom_range(15, 0));
    lim = days_in_month(t.month, t.year);
    if (lim == 0 || $urandom_range(99) < 10) t.day = DAY_W'($urandom_range(31, 0));
    else t.day = DAY_W'($urandom_range(lim, 1));
    return t;
  endfunction

  // Most pairs are realistic dates around the valid-year floor, arranged so
  // that the ordering has to look at month and day as well as year. A share
  // lands right next to the current date, and a quarter is raw noise that
  // toggles every bit of every field.
  function automatic date_pair_t random_pair();
    date_pair_t  p;
    logic [63:0] rnd;
    int unsigned kind;
    kind = $urandom_range(99);
    rnd  = {$urandom, $urandom};
    p    = rnd[$bits(date_pair_t)-1:0];
    if (kind < 25) return p;
    if (kind < 30) begin
      p.a = plausible_date(0, MAX_YEAR);
      p.b = plausible_date(0, MAX_YEAR);
    end else if (kind < 50) begin
      p.a = plausible_date(1940, 2110);
      p.b = plausible_date(1940, 2110);
    end else if (kind < 63) begin
      p.a = plausible_date(1940, 2110);
      p.b = plausible_date(p.a.year, p.a.year);
    end else if (kind < 73) begin
      p.a = plausible_date(1940, 2110);
      p.b = p.a;
      p.b.day = DAY_W'($urandom_range(31, 0));
    end else if (kind < 78) begin
      p.a = plausible_date(1940, 2110);
      p.b = p.a;
    end else begin
      // The current date itself or one step either side of it, in day or month.
      p.a = cur_date;
      case ($urandom_range(4))
        0: p.a.day   = p.a.day + DAY_W'(1);
        1: p.a.day   = p.a.day - DAY_W'(1);
        2: p.a.month = p.a.month + MON_W'(1);
        3: p.a.month = p.a.month - MON_W'(1);
        default: ;
      endcase
      p.b = plausible_date(1940, 2110);
    end
    return p;
  endfunction

  // Idle lengths for both sides: mostly none or short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Compares one output beat with the oldest pending prediction.
  task automatic check_result(logic [OUT_DATA_W-1:0] word);
    date_verdict_t           want;
    logic signed [CNT_W-1:0] got_days;
    results_seen++;
    if (expected_verdicts.size() == 0) begin
      report_mismatch($sformatf("result beat %0d (0x%08h) with nothing expected",
                                results_seen, word));
      return;
    end
    want     = expected_verdicts.pop_front();
    got_days = word[CNT_W+2:3];
    if (word[0] !== want.a_valid)
      report_mismatch($sformatf("beat %0d a_valid: expected %0b, got %0b",
                                results_seen, want.a_valid, word[0]));
    if (word[1] !== want.a_not_before_cur)
      report_mismatch($sformatf("beat %0d a_not_before_current: expected %0b, got %0b",
                                results_seen, want.a_not_before_cur, word[1]));
    if (word[2] !== want.a_not_before_b)
      report_mismatch($sformatf("beat %0d a_not_before_b: expected %0b, got %0b",
                                results_seen, want.a_not_before_b, word[2]));
    if (got_days !== want.days)
      report_mismatch($sformatf("beat %0d days_between: expected %0d, got %0d",
                                results_seen, want.days, got_days));
  endtask

  // Register writes go out on the falling edge and take effect at the next
  // rising edge; the local copy follows once the write has landed.
  task automatic write_reg(dgd_cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CUR_DAY:   cur_date.day   = value[DAY_W-1:0];
      CFG_CUR_MONTH: cur_date.month = value[MON_W-1:0];
      CFG_CUR_YEAR:  cur_date.year  = value[YEAR_W-1:0];
      default: ;
    endcase
  endtask

  // Returns once every queued pair has been sent and every prediction has been
  // matched. Sampling on the falling edge sees all rising-edge updates settled.
  task automatic wait_for_drain();
    while (pending_pairs.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
      @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: presents the next queued pair, holds it until it is taken, then
  // sits out a random gap before the next one.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && !(s_tvalid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        s_tdata  <= {{(IN_DATA_W - $bits(date_pair_t)){1'b0}}, pending_pairs.pop_front()};
        s_tvalid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: ready for one cycle, then stalled for a random stretch. The
  // stalls run regardless of whether a beat is waiting, so they hit the
  // pipeline in every state of fill.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Monitor: output beats are checked before the input beat of the same edge is
  // predicted, since that input cannot be the source of this output.
  always @(posedge clk_i) begin
    in_taken = rst_ni && s_tvalid && s_tready;
    if (rst_ni) begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (in_taken) begin
        expected_verdicts.push_back(judge_dates(s_tdata[$bits(date_pair_t)-1:0]));
        pairs_sent++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results still outstanding",
               cycle_count, expected_verdicts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Corner cases under the reset date 1/1/1951.
    pending_pairs.push_back(make_pair(29, 2, 2000,   1, 1, 1951));  // divisible by 400: leap
    pending_pairs.push_back(make_pair(29, 2, 2100,  28, 2, 2100));  // century: not leap
    pending_pairs.push_back(make_pair(29, 2, 2004,   1, 3, 2004));
    pending_pairs.push_back(make_pair(29, 2, 1951,  29, 2, 1952));
    pending_pairs.push_back(make_pair( 1, 1, 1950,   1, 1, 1951));  // at the year floor
    pending_pairs.push_back(make_pair( 1, 1, 1951,   1, 1, 1951));  // equal dates, equal current
    pending_pairs.push_back(make_pair(31, 12, 1950,  1, 1, 1951));
    pending_pairs.push_back(make_pair( 0, 5, 2020,   1, 5, 2020));  // day zero
    pending_pairs.push_back(make_pair(31, 4, 2021,  30, 4, 2021));  // past the end of April
    pending_pairs.push_back(make_pair(31, 12, 16383, 1, 1, 0));     // widest span
    pending_pairs.push_back(make_pair( 1, 1, 0,     31, 12, 16383));
    pending_pairs.push_back(make_pair(31, 12, 2000,  0, 13, 2000)); // count of -31
    pending_pairs.push_back(make_pair(15, 0, 2022,  15, 15, 2022));
    pending_pairs.push_back(make_pair(10, 13, 2022, 10, 12, 2022));
    pending_pairs.push_back(make_pair(31, 15, 16383, 31, 15, 16383)); // all ones
    pending_pairs.push_back(make_pair( 0, 0, 0,      0, 0, 0));       // all zeros
    pending_pairs.push_back(make_pair(29, 2, 0,      1, 3, 0));       // year 0 is leap
    pending_pairs.push_back(make_pair(31, 1, 1999,   1, 2, 1999));
    pending_pairs.push_back(make_pair( 1, 1, 2400,  31, 12, 2399));
    pending_pairs.push_back(make_pair(30, 6, 1951,   2, 7, 1951));
    pending_pairs.push_back(make_pair(31, 12, 1951,  1, 1, 1952));
    repeat (RANDOM_PER_PHASE) pending_pairs.push_back(random_pair());
    wait_for_drain();

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      // Let the pipeline empty completely before touching the registers.
      repeat (PIPE_DEPTH + 2) @(negedge clk_i);
      write_reg(CFG_CUR_DAY,   CFG_DATA_W'(SET_DAY[ph]));
      write_reg(CFG_CUR_MONTH, CFG_DATA_W'(SET_MON[ph]));
      write_reg(CFG_CUR_YEAR,  CFG_DATA_W'(SET_YEAR[ph]));
      // Every other phase runs without any idle cycles on either side.
      steady = (ph % 2 == 1);
      repeat (RANDOM_PER_PHASE) pending_pairs.push_back(random_pair());
      wait_for_drain();
    end

    // Any beat the block emits beyond the predictions shows up in this window.
    repeat (4 * PIPE_DEPTH) @(negedge clk_i);

    $display("Sent %0d date pairs and checked %0d result beats under %0d current-date settings.",
             pairs_sent, results_seen, N_SETTINGS + 1);
    $display("Covered leap-year rules, month and day limits, odd months and random stalls.");
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
